FILE: src/spe_pkg.sv
`default_nettype none
package spe_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned EW = 5;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_DERIV  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_POW,
    ST_TERM,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [QW-1:0] value;
    logic          divide_by_zero;
    logic          overflow;
    logic          table_full;
  } result_t;

  typedef struct packed {
    logic [1:0]    command;
    logic [QW-1:0] coefficient;
    logic [EW-1:0] exponent;
    logic [QW-1:0] point;
  } request_t;

  function automatic logic [QW-1:0] sat64(input logic signed [63:0] v, output logic ovf);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    ovf = 1'b0;
    if (v > mx) begin
      ovf = 1'b1;
      sat64 = 32'h7fffffff;
    end else if (v < mn) begin
      ovf = 1'b1;
      sat64 = 32'h80000000;
    end else begin
      sat64 = v[QW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/spe_if.sv
`default_nettype none
interface spe_req_if;
  logic              valid;
  logic              ready;
  spe_pkg::request_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface spe_rsp_if;
  logic             valid;
  logic             ready;
  spe_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/sparse_polynomial_evaluator_top.sv
`default_nettype none
// Clear and append: the request is taken in ST_IDLE and passes ST_LOAD, then ST_OUT,
// where the result is registered. Evaluate: each term passes ST_TERM, then ST_POW with
// one multiply per unit of exponent magnitude, ST_DIV in the serial divider for a negative
// exponent, and ST_ACC; a skipped derivative term with exponent zero passes only ST_TERM.
// One request at a time; a stalled result holds the block until it is taken.
// Reset (async, active low) empties the table; term storage is not cleared.
module sparse_polynomial_evaluator_top #(
  parameter int unsigned MAX_TERMS = 16,
  parameter int unsigned EXP_MAX   = 15,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spe_req_if.sink   req_i,
  spe_rsp_if.source rsp_o
);
  import spe_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  state_e state_q, state_d;
  request_t req_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] walk_q, walk_d;
  result_t res_q, res_d;
  logic rsp_valid_q, rsp_valid_d;

  // Chain of term cells: cell 0 is the head, read by the datapath
  logic [QW-1:0] cell_coef [MAX_TERMS];
  logic [EW-1:0] cell_exp  [MAX_TERMS];
  logic [MAX_TERMS-1:0] cell_load;
  logic          walk_shift;

  logic signed [EW-1:0] app_exp;
  always_comb begin
    app_exp = req_q.exponent;
    if (int'($signed(req_q.exponent)) > int'(EXP_MAX)) app_exp = EW'(EXP_MAX);
    if (int'($signed(req_q.exponent)) < -int'(EXP_MAX)) app_exp = -EW'(EXP_MAX);
  end

  // Append goes at the tail slot; the walk rotates head back to the tail
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    logic [QW-1:0] prev_coef;
    logic [EW-1:0] prev_exp;
    logic          rot_in;
    assign rot_in    = (CW'(g) == count_q - CW'(1));
    assign prev_coef = rot_in ? cell_coef[0] :
                       cell_coef[(g + 1) % MAX_TERMS];
    assign prev_exp  = rot_in ? cell_exp[0] : cell_exp[(g + 1) % MAX_TERMS];
    spe_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (cell_load[g]),
      .shift_i     (walk_shift && (CW'(g) < count_q)),
      .load_coef_i (req_q.coefficient),
      .load_exp_i  (app_exp),
      .prev_coef_i (prev_coef),
      .prev_exp_i  (prev_exp),
      .coef_o      (cell_coef[g]),
      .exp_o       (cell_exp[g])
    );
  end

  // Term datapath registers
  logic signed [31:0] coef_q, coef_d;
  logic signed [EW:0] e_q, e_d;
  logic [EW:0]        k_q, k_d;
  logic signed [31:0] pow_q, pow_d;
  logic signed [31:0] sum_q, sum_d;
  logic signed [31:0] term_q, term_d;
  logic               ovf_q, ovf_d, dz_q, dz_d;
  logic               div_start;
  logic               div_done;
  logic signed [63:0] div_quo;

  spe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ($signed({{32{coef_q[31]}}, coef_q}) <<< FRAC_BITS),
    .divisor_i  (pow_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic signed [63:0] prod;
  logic signed [63:0] fl;
  logic signed [63:0] dprod;
  logic               sat_o;
  logic signed [EW:0] head_e;
  logic               last_term;

  always_comb begin
    head_e    = $signed({cell_exp[0][EW-1], cell_exp[0]});
    last_term = (walk_q == count_q - CW'(1));
    prod      = $signed(pow_q) * $signed({{32{req_q.point[31]}}, req_q.point});
    dprod     = '0;
    fl        = '0;
    sat_o     = 1'b0;
    state_d   = state_q;
    count_d   = count_q;
    walk_d    = walk_q;
    res_d     = res_q;
    coef_d    = coef_q;
    e_d       = e_q;
    k_d       = k_q;
    pow_d     = pow_q;
    sum_d     = sum_q;
    term_d    = term_q;
    ovf_d     = ovf_q;
    dz_d      = dz_q;
    cell_load = '0;
    walk_shift = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        res_d = '0;
        sum_d = '0;
        ovf_d = 1'b0;
        dz_d  = 1'b0;
        walk_d = '0;
        case (cmd_e'(req_q.command))
          CMD_CLEAR: begin
            count_d = '0;
            state_d = ST_OUT;
          end
          CMD_APPEND: begin
            if (count_q >= CW'(MAX_TERMS)) begin
              res_d.table_full = 1'b1;
            end else begin
              cell_load[count_q[IW-1:0]] = 1'b1;
              count_d = count_q + CW'(1);
            end
            state_d = ST_OUT;
          end
          default: begin
            state_d = (count_q == '0) ? ST_OUT : ST_TERM;
          end
        endcase
        e_d = '0;
      end
      ST_TERM: begin
        // Set up the head term, or skip it in derivative mode when its exponent is zero
        if (cmd_e'(req_q.command) == CMD_DERIV && head_e == '0) begin
          walk_shift = 1'b1;
          walk_d = walk_q + CW'(1);
          if (last_term) state_d = ST_OUT;
        end else begin
          if (cmd_e'(req_q.command) == CMD_DERIV) begin
            dprod  = $signed({{32{cell_coef[0][31]}}, cell_coef[0]}) * 64'(head_e);
            coef_d = sat64(dprod, sat_o);
            if (sat_o) ovf_d = 1'b1;
            e_d    = head_e - (EW+1)'(1);
          end else begin
            coef_d = cell_coef[0];
            e_d    = head_e;
          end
          k_d     = e_d[EW] ? (EW+1)'(-e_d) : e_d;
          pow_d   = 32'(ONE);
          if (ONE > 64'sd2147483647) begin
            pow_d = 32'h7fffffff;
            ovf_d = 1'b1;
          end
          state_d = ST_POW;
        end
      end
      ST_POW: begin
        if (k_q != '0) begin
          fl    = prod >>> FRAC_BITS;
          pow_d = sat64(fl, sat_o);
          if (sat_o) ovf_d = 1'b1;
          k_d   = k_q - (EW+1)'(1);
        end else if (e_q[EW]) begin
          if (pow_q == '0) begin
            dz_d    = 1'b1;
            term_d  = '0;
            state_d = ST_ACC;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else begin
          fl      = ($signed({{32{coef_q[31]}}, coef_q}) * $signed({{32{pow_q[31]}}, pow_q}))
                    >>> FRAC_BITS;
          term_d  = sat64(fl, sat_o);
          if (sat_o) ovf_d = 1'b1;
          state_d = ST_ACC;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          term_d  = sat64(div_quo, sat_o);
          if (sat_o) ovf_d = 1'b1;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d = sat64(64'(sum_q) + 64'(term_q), sat_o);
        if (sat_o) ovf_d = 1'b1;
        walk_shift = 1'b1;
        walk_d = walk_q + CW'(1);
        state_d = last_term ? ST_OUT : ST_TERM;
      end
      ST_OUT: begin
        if (cmd_e'(req_q.command) == CMD_EVAL || cmd_e'(req_q.command) == CMD_DERIV) begin
          res_d.value = sum_d;
          res_d.overflow = ovf_q;
          res_d.divide_by_zero = dz_q;
        end
        if (!rsp_valid_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Response valid: cleared when the result is taken, set when ST_OUT registers a result
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) rsp_valid_d = 1'b0;
    if (state_q == ST_OUT && (!rsp_valid_q || rsp_o.ready)) rsp_valid_d = 1'b1;
  end

  logic [QW-1:0] rsp_q;
  logic rsp_flags_dz_q, rsp_flags_ovf_q, rsp_flags_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) req_q <= req_i.payload;
    coef_q <= coef_d;
    e_q    <= e_d;
    k_q    <= k_d;
    pow_q  <= pow_d;
    sum_q  <= sum_d;
    term_q <= term_d;
    ovf_q  <= ovf_d;
    dz_q   <= dz_d;
    res_q  <= res_d;
    if (state_q == ST_OUT && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_q            <= res_d.value;
      rsp_flags_dz_q   <= res_d.divide_by_zero;
      rsp_flags_ovf_q  <= res_d.overflow;
      rsp_flags_full_q <= res_d.table_full;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.payload.value          = rsp_q;
  assign rsp_o.payload.divide_by_zero = rsp_flags_dz_q;
  assign rsp_o.payload.overflow       = rsp_flags_ovf_q;
  assign rsp_o.payload.table_full     = rsp_flags_full_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TERMS))
    else $error("term count beyond capacity");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM) |-> (walk_q < count_q))
    else $error("walk past last term");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == ST_LOAD))
    else $error("request not loaded");
endmodule
`default_nettype wire

FILE: src/spe_cell.sv
`default_nettype none
// One table slot: hold a term, shift toward the head on a walk
module spe_cell (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      shift_i,
  input  logic [spe_pkg::QW-1:0]    load_coef_i,
  input  logic [spe_pkg::EW-1:0]    load_exp_i,
  input  logic [spe_pkg::QW-1:0]    prev_coef_i,
  input  logic [spe_pkg::EW-1:0]    prev_exp_i,
  output logic [spe_pkg::QW-1:0]    coef_o,
  output logic [spe_pkg::EW-1:0]    exp_o
);
  import spe_pkg::*;
  logic [QW-1:0] coef_q;
  logic [EW-1:0] exp_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      coef_q <= load_coef_i;
      exp_q  <= load_exp_i;
    end else if (shift_i) begin
      coef_q <= prev_coef_i;
      exp_q  <= prev_exp_i;
    end
  end

  assign coef_o = coef_q;
  assign exp_o  = exp_q;
endmodule
`default_nettype wire

FILE: src/spe_divider.sv
`default_nettype none
// Restoring signed divide, one quotient bit per cycle, truncate toward zero
module spe_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [63:0]       dividend_i,
  input  logic signed [31:0]       divisor_i,
  output logic                     done_o,
  output logic signed [63:0]       quotient_o
);
  import spe_pkg::*;
  logic [63:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [64:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      num_d  = dividend_i[63] ? 64'(-dividend_i) : dividend_i;
      den_d  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      neg_d  = dividend_i[63] ^ divisor_i[31];
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[63:0], num_q[63]};
      num_d = {num_q[62:0], 1'b0};
      if (trial >= {33'd0, den_q}) begin
        rem_d    = trial - {33'd0, den_q};
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? 64'(-$signed(num_q)) : $signed(num_q);
endmodule
`default_nettype wire
